>>> design/aftm_pkg.sv
// ----------------------------------------------------------------------------
// aftm_pkg
// Shared types, tree geometry and operation codes for the adaptive
// frequency tree model.
// ----------------------------------------------------------------------------
package aftm_pkg;

	localparam int NUM_SYMBOLS = 257;
	localparam int MAX_LEVELS  = 16;
	localparam int LVL_W       = $clog2(MAX_LEVELS);

	localparam int SYM_W = 10;
	localparam int CNT_W = 16;

	// Width of a symbol index that is known to be below NUM_SYMBOLS.
	localparam int SIDX_W = $clog2(NUM_SYMBOLS);

	typedef enum logic [1:0] {
		OP_DECODE = 2'd0,
		OP_INCR   = 2'd1,
		OP_HALVE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Number of tree levels, leaves through root.
	function automatic int calc_levels();
		int n;
		int cnt;
		bit done;
		n    = NUM_SYMBOLS;
		cnt  = 0;
		done = 1'b0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (!done) begin
				cnt++;
				if (n <= 1) begin
					done = 1'b1;
				end else begin
					n = (n + 1) >> 1;
				end
			end
		end
		return cnt;
	endfunction

	localparam int LEVELS = calc_levels();

	// Total number of entries over all levels.
	function automatic int calc_store();
		int n;
		int sum;
		n   = NUM_SYMBOLS;
		sum = 0;
		for (int k = 0; k < LEVELS; k++) begin
			sum = sum + n;
			n   = (n + 1) >> 1;
		end
		return sum;
	endfunction

	localparam int STORE_SIZE = calc_store();
	localparam int IDX_W      = $clog2(STORE_SIZE);
	localparam int ROOT_IDX   = STORE_SIZE - 1;

	typedef logic [MAX_LEVELS-1:0][IDX_W-1:0] lvl_tab_t;

	function automatic lvl_tab_t calc_size();
		lvl_tab_t t;
		int n;
		t = '0;
		n = NUM_SYMBOLS;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (k < LEVELS) begin
				t[k] = IDX_W'(n);
				n    = (n + 1) >> 1;
			end
		end
		return t;
	endfunction

	function automatic lvl_tab_t calc_off();
		lvl_tab_t t;
		int n;
		int off;
		t   = '0;
		n   = NUM_SYMBOLS;
		off = 0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (k < LEVELS) begin
				t[k] = IDX_W'(off);
				off  = off + n;
				n    = (n + 1) >> 1;
			end
		end
		return t;
	endfunction

	localparam lvl_tab_t LVL_SIZE = calc_size();
	localparam lvl_tab_t LVL_OFF  = calc_off();

	typedef struct packed {
		logic [1:0]       operation;
		logic [CNT_W-1:0] value;
		logic [SYM_W-1:0] symbol;
	} req_t;

	typedef struct packed {
		logic [SYM_W-1:0] decoded_symbol;
		logic [CNT_W-1:0] low_sum;
		logic [CNT_W-1:0] symbol_count;
		logic [CNT_W-1:0] total_count;
		logic             symbol_present;
		logic             error;
	} rsp_t;

endpackage

>>> design/adaptive_frequency_tree_model.sv
// ----------------------------------------------------------------------------
// adaptive_frequency_tree_model
// Adaptive symbol-frequency tree for an arithmetic decoder, held in one
// synchronous memory with one read and one write port.
// Decode and increment walk the tree with one memory read per tree level;
// a halve walks every leaf and then rebuilds the upper levels, one entry
// per cycle. One transaction at a time: the next one can be taken in the
// same cycle as the result is raised, and a new result waits while the
// previous one is held by rsp_stall.
// After reset the block clears every memory entry before it takes its first
// transaction.
// ----------------------------------------------------------------------------
module adaptive_frequency_tree_model (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  aftm_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output aftm_pkg::rsp_t    rsp
);

	// Sequencer states. Each state that processes memory data sees the read
	// that was issued in the cycle before.
	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,  // clearing pass after reset
		ST_IDLE  = 9'b000000010,  // ready for a new transaction
		ST_DEC   = 9'b000000100,  // decode descent, one level per cycle
		ST_DECF  = 9'b000001000,  // leaf count of the decoded symbol
		ST_INC   = 9'b000010000,  // increment walk, leaf to root
		ST_HLV   = 9'b000100000,  // halve every leaf
		ST_REB   = 9'b001000000,  // rebuild the upper levels from below
		ST_PRES  = 9'b010000000,  // read the queried symbol's leaf
		ST_PRESW = 9'b100000000   // form the result
	} state_t;

	localparam int IDX_W  = aftm_pkg::IDX_W;
	localparam int SIDX_W = aftm_pkg::SIDX_W;
	localparam int LVL_W  = aftm_pkg::LVL_W;
	localparam int CNT_W  = aftm_pkg::CNT_W;
	localparam int SYM_W  = aftm_pkg::SYM_W;

	localparam logic [SYM_W:0]   SYM_LIMIT  = (SYM_W+1)'(aftm_pkg::NUM_SYMBOLS);
	localparam logic [IDX_W-1:0] LAST_LEAF  = IDX_W'(aftm_pkg::NUM_SYMBOLS - 1);
	localparam logic [IDX_W-1:0] ROOT_ADDR  = IDX_W'(aftm_pkg::ROOT_IDX);
	localparam logic [LVL_W-1:0] TOP_LVL    = LVL_W'(aftm_pkg::LEVELS - 1);
	localparam logic [LVL_W-1:0] BELOW_ROOT = LVL_W'(aftm_pkg::LEVELS - 2);
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;

	// Count memory, one read and one write per cycle, registered read data.
	logic [CNT_W-1:0] mem [aftm_pkg::STORE_SIZE];
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [CNT_W-1:0] rd_data_q;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [CNT_W-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control and working registers.
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  addr_q, addr_d;
	logic [LVL_W-1:0]  lvl_q, lvl_d;
	logic [SIDX_W-1:0] s_q, s_d;
	logic [SIDX_W-1:0] j_q, j_d;
	logic [CNT_W-1:0]  total_q;
	logic              out_valid_q, out_valid_d;

	// Transaction payload and partial results.
	logic [SYM_W-1:0]  sym_q, sym_d;
	logic [CNT_W-1:0]  val_q, val_d;
	logic [CNT_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]  low_q, low_d;
	logic [CNT_W-1:0]  freq_q, freq_d;
	logic [SYM_W-1:0]  dsym_q, dsym_d;
	logic              err_q, err_d;
	aftm_pkg::rsp_t    out_q, out_d;

	// Helpers.
	logic [IDX_W-1:0]  lvl_size;
	logic [IDX_W:0]    s_plus1;
	logic              has_right;
	logic              take;
	logic [SIDX_W-1:0] s_new;
	logic [SIDX_W-1:0] s_dn;
	logic              last_in_lvl;
	logic              sym_valid;
	logic              req_acc;
	logic              out_free;
	logic [CNT_W-1:0]  pair_sum;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign out_free  = !out_valid_q || !rsp_stall;

	assign lvl_size  = aftm_pkg::LVL_SIZE[lvl_q];
	assign sym_valid = ({1'b0, sym_q} < SYM_LIMIT);

	// Decode step: go right when there is a right sibling and the value
	// reaches past the left child's count.
	assign s_plus1   = (IDX_W+1)'(s_q) + (IDX_W+1)'(1);
	assign has_right = (s_plus1 < {1'b0, lvl_size});
	assign take      = has_right && (val_q >= rd_data_q);
	assign s_new     = s_q + SIDX_W'(take);
	assign s_dn      = SIDX_W'({s_new, 1'b0});

	assign last_in_lvl = (IDX_W'(j_q) == lvl_size - IDX_W'(1));
	assign pair_sum    = acc_q + rd_data_q;

	always_comb begin
		state_d     = state_q;
		addr_d      = addr_q;
		lvl_d       = lvl_q;
		s_d         = s_q;
		j_d         = j_q;
		sym_d       = sym_q;
		val_d       = val_q;
		acc_d       = acc_q;
		low_d       = low_q;
		freq_d      = freq_q;
		dsym_d      = dsym_q;
		err_d       = err_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && rsp_stall;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = addr_q;
		wr_data     = '0;

		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = addr_q;
				wr_data = '0;
				if (addr_q == ROOT_ADDR) begin
					state_d = ST_IDLE;
				end else begin
					addr_d = addr_q + IDX_W'(1);
				end
			end

			ST_IDLE: begin
				if (req_acc) begin
					sym_d  = req.symbol;
					val_d  = req.value;
					low_d  = '0;
					freq_d = '0;
					dsym_d = '0;
					err_d  = 1'b0;
					case (aftm_pkg::op_t'(req.operation))
						aftm_pkg::OP_DECODE: begin
							if (req.value >= total_q) begin
								err_d   = 1'b1;
								state_d = ST_PRES;
							end else begin
								s_d     = '0;
								lvl_d   = BELOW_ROOT;
								rd_en   = 1'b1;
								rd_addr = aftm_pkg::LVL_OFF[BELOW_ROOT];
								state_d = ST_DEC;
							end
						end
						aftm_pkg::OP_INCR: begin
							if (total_q == CNT_MAX) begin
								err_d   = 1'b1;
								state_d = ST_PRES;
							end else if ({1'b0, req.symbol} < SYM_LIMIT) begin
								s_d     = req.symbol[SIDX_W-1:0];
								lvl_d   = '0;
								addr_d  = IDX_W'(req.symbol[SIDX_W-1:0]);
								rd_en   = 1'b1;
								rd_addr = IDX_W'(req.symbol[SIDX_W-1:0]);
								state_d = ST_INC;
							end else begin
								state_d = ST_PRES;
							end
						end
						aftm_pkg::OP_HALVE: begin
							addr_d  = '0;
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = ST_HLV;
						end
						default: begin
							state_d = ST_PRES;
						end
					endcase
				end
			end

			ST_DEC: begin
				if (take) begin
					low_d = low_q + rd_data_q;
					val_d = val_q - rd_data_q;
				end
				if (lvl_q == '0) begin
					dsym_d  = SYM_W'(s_new);
					rd_en   = 1'b1;
					rd_addr = IDX_W'(s_new);
					state_d = ST_DECF;
				end else begin
					s_d     = s_dn;
					lvl_d   = lvl_q - LVL_W'(1);
					rd_en   = 1'b1;
					rd_addr = aftm_pkg::LVL_OFF[lvl_q - LVL_W'(1)] + IDX_W'(s_dn);
				end
			end

			ST_DECF: begin
				// Decode writes nothing, so the presence read can follow at once.
				freq_d  = rd_data_q;
				rd_en   = 1'b1;
				rd_addr = IDX_W'(sym_q[SIDX_W-1:0]);
				state_d = ST_PRESW;
			end

			ST_INC: begin
				wr_en   = 1'b1;
				wr_addr = addr_q;
				wr_data = rd_data_q + CNT_W'(1);
				if (lvl_q == TOP_LVL) begin
					state_d = ST_PRES;
				end else begin
					s_d     = s_q >> 1;
					lvl_d   = lvl_q + LVL_W'(1);
					rd_en   = 1'b1;
					rd_addr = aftm_pkg::LVL_OFF[lvl_q + LVL_W'(1)] + IDX_W'(s_q >> 1);
					addr_d  = rd_addr;
				end
			end

			ST_HLV: begin
				wr_en   = 1'b1;
				wr_addr = addr_q;
				wr_data = rd_data_q >> 1;
				rd_en   = 1'b1;
				if (addr_q == LAST_LEAF) begin
					rd_addr = '0;
					addr_d  = '0;
					lvl_d   = '0;
					j_d     = '0;
					state_d = ST_REB;
				end else begin
					rd_addr = addr_q + IDX_W'(1);
					addr_d  = rd_addr;
				end
			end

			ST_REB: begin
				// Levels lie back to back, so the read address simply counts up
				// while the level and the index within it follow along.
				wr_addr = aftm_pkg::LVL_OFF[lvl_q + LVL_W'(1)] + IDX_W'(j_q >> 1);
				if (j_q[0]) begin
					wr_en   = 1'b1;
					wr_data = pair_sum;
				end else begin
					acc_d   = rd_data_q;
					wr_en   = last_in_lvl;
					wr_data = rd_data_q;
				end
				if (last_in_lvl && lvl_q == BELOW_ROOT) begin
					state_d = ST_PRES;
				end else begin
					rd_en   = 1'b1;
					rd_addr = addr_q + IDX_W'(1);
					addr_d  = rd_addr;
					if (last_in_lvl) begin
						lvl_d = lvl_q + LVL_W'(1);
						j_d   = '0;
					end else begin
						j_d   = j_q + SIDX_W'(1);
					end
				end
			end

			ST_PRES: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(sym_q[SIDX_W-1:0]);
				state_d = ST_PRESW;
			end

			ST_PRESW: begin
				if (out_free) begin
					out_d.decoded_symbol = dsym_q;
					out_d.low_sum        = low_q;
					out_d.symbol_count   = freq_q;
					out_d.total_count    = total_q;
					out_d.symbol_present = sym_valid && (rd_data_q != '0);
					out_d.error          = err_q;
					out_valid_d          = 1'b1;
					state_d              = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			lvl_q       <= '0;
			s_q         <= '0;
			j_q         <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			addr_q      <= addr_d;
			lvl_q       <= lvl_d;
			s_q         <= s_d;
			j_q         <= j_d;
			out_valid_q <= out_valid_d;
			// The root is mirrored here so the total never needs a read.
			if (wr_en && wr_addr == ROOT_ADDR) begin
				total_q <= wr_data;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		sym_q  <= sym_d;
		val_q  <= val_d;
		acc_q  <= acc_d;
		low_q  <= low_d;
		freq_q <= freq_d;
		dsym_q <= dsym_d;
		err_q  <= err_d;
		out_q  <= out_d;
	end

endmodule
